// ===== rtl/pngt_pkg.sv =====
// shared types and constants for the per-node sequence gap tracker
// no dependencies; imported by every module of the block
package pngt_pkg;

  localparam int MaxNodes   = 8;
  localparam int SlotW      = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int CountW     = $clog2(MaxNodes + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegSessionTag = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCentralId  = 2'd1;

  localparam logic [5:0] FrameMinBytes = 6'd24;
  localparam logic [7:0] TypeMocap     = 8'hC1;

  localparam logic [1:0] StAccepted = 2'd0;
  localparam logic [1:0] StRejected = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef struct packed {
    logic [5:0]  frame_len;
    logic [7:0]  frame_type;
    logic [7:0]  node_id;
    logic [7:0]  sequence_req;
    logic [7:0]  frame_session;
    logic [31:0] node_time;
    logic [31:0] synced_time;
    logic [31:0] rx_time;
    logic [2:0]  pipe;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic        new_node;
    logic [7:0]  out_node_id;
    logic [7:0]  out_sequence;
    logic [7:0]  gap_count;
    logic [31:0] node_total_gaps;
    logic [31:0] node_packets;
    logic [3:0]  tracked_count;
    logic [7:0]  anchor_seq;
    logic [2:0]  anchor_pipe;
    logic [31:0] anchor_time;
  } result_t;

  // classified word passed from front to back
  typedef struct packed {
    item_t item;
    logic  reject;
  } qentry_t;

  // queue handshake between the two halves
  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

endpackage

// ===== rtl/pngt_front.sv =====
// front end: config registers, frame acceptance and header screening
// depends on pngt_pkg
module pngt_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  pngt_pkg::item_t                 item_i,
  input  logic                            cfg_we_i,
  input  logic [pngt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pngt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output logic                            push_o,
  output pngt_pkg::qentry_t               entry_o
);
  import pngt_pkg::*;

  logic [7:0] session_tag_q, session_tag_d;
  logic [7:0] central_id_q, central_id_d;

  always_comb begin
    session_tag_d = session_tag_q;
    central_id_d  = central_id_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSessionTag: session_tag_d = cfg_wdata_i;
        RegCentralId:  central_id_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_tag_q <= '0;
      central_id_q  <= '0;
    end else begin
      session_tag_q <= session_tag_d;
      central_id_q  <= central_id_d;
    end
  end

  assign push_o       = accept_i;
  assign entry_o.item = item_i;
  assign entry_o.reject = (item_i.frame_len < FrameMinBytes) ||
                          (item_i.frame_type != TypeMocap) ||
                          (item_i.frame_session != session_tag_q);

endmodule

// ===== rtl/pngt_fifo.sv =====
// short queue of classified words between front and back
// depends on pngt_pkg
module pngt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pngt_pkg::qctl_t    ctl_i,
  input  pngt_pkg::qentry_t  wdata_i,
  output logic               not_empty_o,
  output logic               full_o,
  output pngt_pkg::qentry_t  rdata_o
);
  import pngt_pkg::*;

  qentry_t            mem_q [QueueDepth];
  logic [QPtrW-1:0]   wptr_q, rptr_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign not_empty_o = (cnt_q != '0);
  assign full_o      = (cnt_q == QCntW'(QueueDepth));
  assign do_push     = ctl_i.push && !full_o;
  assign do_pop      = ctl_i.pop && not_empty_o;
  assign rdata_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/pngt_back.sv =====
// back end: node table lookup, slot allocation, gap and counter update
// depends on pngt_pkg
module pngt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  pngt_pkg::qentry_t  q_entry_i,
  output logic               pop_o,
  output logic               done_o,
  output pngt_pkg::result_t  result_o
);
  import pngt_pkg::*;

  localparam logic [1:0] BkIdle = 2'd0;
  localparam logic [1:0] BkLook = 2'd1;
  localparam logic [1:0] BkUpd  = 2'd2;

  logic [1:0] state_q, state_d;

  // node table
  logic              valid_q [MaxNodes];
  logic [7:0]        node_q  [MaxNodes];
  logic [31:0]       pkts_q  [MaxNodes];
  logic [31:0]       gaps_q  [MaxNodes];
  logic [7:0]        lseq_q  [MaxNodes];
  logic [31:0]       ntime_q [MaxNodes];
  logic [31:0]       stime_q [MaxNodes];
  logic [31:0]       rtime_q [MaxNodes];
  logic [CountW-1:0] occ_q;
  logic [7:0]        anchor_q;

  qentry_t           cur_q;
  logic              found_q, full_q;
  logic [SlotW-1:0]  idx_q;

  logic              found, free_ok;
  logic [SlotW-1:0]  hit_idx, free_idx;

  logic [31:0]       pk, new_pk, new_gaps;
  logic [7:0]        gap;
  logic [CountW-1:0] occ_nx;
  logic              commit;
  result_t           res_d, res_q;
  logic              done_q;

  // first matching slot wins, else lowest free slot
  always_comb begin
    found    = 1'b0;
    free_ok  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < MaxNodes; i++) begin
      if (valid_q[i] && (node_q[i] == cur_q.item.node_id) && !found) begin
        found   = 1'b1;
        hit_idx = SlotW'(i);
      end
      if (!valid_q[i] && !free_ok) begin
        free_ok  = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  always_comb begin
    pk       = pkts_q[idx_q];
    gap      = (pk != '0) ? (cur_q.item.sequence_req - (lseq_q[idx_q] + 8'd1)) : 8'd0;
    new_gaps = gaps_q[idx_q] + {24'd0, gap};
    new_pk   = pk + 32'd1;
    occ_nx   = found_q ? occ_q : occ_q + 1'b1;
    commit   = (state_q == BkUpd) && !cur_q.reject && !full_q;

    res_d = '0;
    if (cur_q.reject) begin
      res_d.status        = StRejected;
      res_d.tracked_count = 4'(occ_q);
    end else if (full_q) begin
      res_d.status        = StFull;
      res_d.tracked_count = 4'(occ_q);
    end else begin
      res_d.status          = StAccepted;
      res_d.slot            = 3'(idx_q);
      res_d.new_node        = !found_q;
      res_d.out_node_id     = cur_q.item.node_id;
      res_d.out_sequence    = cur_q.item.sequence_req;
      res_d.gap_count       = gap;
      res_d.node_total_gaps = new_gaps;
      res_d.node_packets    = new_pk;
      res_d.tracked_count   = 4'(occ_nx);
      res_d.anchor_seq      = anchor_q;
      res_d.anchor_pipe     = cur_q.item.pipe;
      res_d.anchor_time     = cur_q.item.rx_time;
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = BkLook;
        end
      end
      BkLook:  state_d = BkUpd;
      BkUpd:   state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_entry_i;
    end
    if (state_q == BkLook) begin
      found_q <= found;
      full_q  <= !found && !free_ok;
      idx_q   <= found ? hit_idx : free_idx;
    end
    if (state_q == BkUpd) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      done_q   <= 1'b0;
      occ_q    <= '0;
      anchor_q <= '0;
      for (int i = 0; i < MaxNodes; i++) begin
        valid_q[i] <= 1'b0;
        node_q[i]  <= '0;
        pkts_q[i]  <= '0;
        gaps_q[i]  <= '0;
        lseq_q[i]  <= '0;
        ntime_q[i] <= '0;
        stime_q[i] <= '0;
        rtime_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == BkUpd);
      if (commit) begin
        valid_q[idx_q] <= 1'b1;
        node_q[idx_q]  <= cur_q.item.node_id;
        pkts_q[idx_q]  <= new_pk;
        gaps_q[idx_q]  <= new_gaps;
        lseq_q[idx_q]  <= cur_q.item.sequence_req;
        ntime_q[idx_q] <= cur_q.item.node_time;
        stime_q[idx_q] <= cur_q.item.synced_time;
        rtime_q[idx_q] <= cur_q.item.rx_time;
        occ_q          <= occ_nx;
        anchor_q       <= anchor_q + 8'd1;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== rtl/per_node_sequence_gap_tracker_core.sv =====
// top level of the per-node sequence gap tracker
// depends on pngt_pkg, pngt_front, pngt_fifo, pngt_back
//
// usage:
//   a frame header is taken on item_i at a rising edge where start is high
//   and busy is low. busy stays high until that frame's result has been
//   shown. the result word appears on result_o for exactly one cycle with
//   done_o high; the receiver cannot hold it off.
//   the result strobe follows the accepting edge once the back-end
//   sequencer has stepped through pop, table lookup, update and result
//   register, and busy drops at the edge that ends it; one frame is in
//   flight at a time.
//   config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at once
//   (0 session tag, 1 central id; other indexes are ignored). write only
//   while busy is low.
//   reset: async active low; clears the node table, the occupied count,
//   the anchor sequence and both config registers. no clearing pass.
module per_node_sequence_gap_tracker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  pngt_pkg::item_t                item_i,
  output logic                           done_o,
  output pngt_pkg::result_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [pngt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pngt_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import pngt_pkg::*;

  logic    busy_q;
  logic    accept;
  qctl_t   qctl;
  qentry_t f_entry, b_entry;
  logic    q_not_empty, q_full;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  pngt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (qctl.push),
    .entry_o     (f_entry)
  );

  pngt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (qctl),
    .wdata_i     (f_entry),
    .not_empty_o (q_not_empty),
    .full_o      (q_full),
    .rdata_o     (b_entry)
  );

  pngt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_not_empty && !q_full || q_not_empty),
    .q_entry_i (b_entry),
    .pop_o     (qctl.pop),
    .done_o    (done_o),
    .result_o  (result_o)
  );

endmodule

// ===== rtl/pngt_chk.sv =====
// port-level checker for the sequence gap tracker, bound to the top level
// depends on pngt_pkg and per_node_sequence_gap_tracker_core
module pngt_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input pngt_pkg::result_t  result_o
);
  import pngt_pkg::*;

  // a result only shows up for a frame in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result word without a frame in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  // busy only drops after the result of that frame
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !done_o) |=> busy) else $error("busy dropped without a result");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("more than one result word per frame");

  // refused frames carry no anchor
  a_no_anchor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != StAccepted) |->
      (result_o.anchor_time == '0 && result_o.node_packets == '0))
    else $error("anchor fields set on a refused frame");

endmodule

bind per_node_sequence_gap_tracker_core pngt_chk u_pngt_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for per_node_sequence_gap_tracker_core: sends frame headers,
// predicts every tracker word from its own node table and compares it field by field
// depends on pngt_pkg and the core rtl only
module testbench;
  import pngt_pkg::*;

  localparam int CycleLimit = 100000;
  localparam int PoolSize   = 10;
  localparam logic [7:0] TypeAnchor = 8'hA1;
  // indexes with no register behind them, writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               item_i;
  logic                done_o;
  result_t             result_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // node table as the tracker should hold it
  logic        tbl_valid       [MaxNodes];
  logic [7:0]  tbl_node        [MaxNodes];
  logic [31:0] tbl_packets     [MaxNodes];
  logic [31:0] tbl_gaps        [MaxNodes];
  logic [7:0]  tbl_last_seq    [MaxNodes];
  logic [31:0] tbl_node_time   [MaxNodes];
  logic [31:0] tbl_synced_time [MaxNodes];
  logic [31:0] tbl_rx_time     [MaxNodes];
  logic [3:0]  tbl_fill;
  logic [7:0]  anchor_next;
  logic [7:0]  cur_session_tag;
  logic [7:0]  cur_central_id;

  logic [7:0]  stim_next_seq [256];
  result_t     expected_reports [$];
  result_t     report_want;
  int          mismatches  = 0;
  int          idle_pct    = 0;
  int          cycle_count = 0;

  per_node_sequence_gap_tracker_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic result_t track_frame(item_t f);
    result_t    r;
    int         i;
    int         hit;
    int         free_idx;
    logic       fresh;
    logic [7:0] gap;
    r = '0;
    hit = -1;
    free_idx = -1;
    fresh = 1'b0;
    gap = '0;
    r.tracked_count = tbl_fill;
    if (f.frame_len < FrameMinBytes || f.frame_type != TypeMocap ||
        f.frame_session != cur_session_tag) begin
      r.status = StRejected;
      return r;
    end
    for (i = 0; i < MaxNodes; i++) begin
      if (hit < 0) begin
        if (tbl_valid[i] && tbl_node[i] == f.node_id) hit = i;
        else if (!tbl_valid[i] && free_idx < 0) free_idx = i;
      end
    end
    if (hit < 0) begin
      if (free_idx < 0) begin
        r.status = StFull;
        return r;
      end
      hit = free_idx;
      tbl_valid[hit] = 1'b1;
      tbl_node[hit] = f.node_id;
      tbl_fill = tbl_fill + 4'd1;
      fresh = 1'b1;
    end
    // no gap on the first word of a slot
    if (tbl_packets[hit] != 32'd0) begin
      gap = f.sequence_req - (tbl_last_seq[hit] + 8'd1);
      tbl_gaps[hit] = tbl_gaps[hit] + {24'd0, gap};
    end
    tbl_packets[hit] = tbl_packets[hit] + 32'd1;
    tbl_last_seq[hit] = f.sequence_req;
    tbl_node_time[hit] = f.node_time;
    tbl_synced_time[hit] = f.synced_time;
    tbl_rx_time[hit] = f.rx_time;
    r.status = StAccepted;
    r.slot = 3'(hit);
    r.new_node = fresh;
    r.out_node_id = f.node_id;
    r.out_sequence = f.sequence_req;
    r.gap_count = gap;
    r.node_total_gaps = tbl_gaps[hit];
    r.node_packets = tbl_packets[hit];
    r.tracked_count = tbl_fill;
    r.anchor_seq = anchor_next;
    r.anchor_pipe = f.pipe;
    r.anchor_time = f.rx_time;
    anchor_next = anchor_next + 8'd1;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $error("tracker word with none pending, status %0d", result_o.status);
        mismatches++;
      end else begin
        report_want = expected_reports.pop_front();
        compare_field("status", 32'(report_want.status), 32'(result_o.status));
        compare_field("slot", 32'(report_want.slot), 32'(result_o.slot));
        compare_field("new_node", 32'(report_want.new_node), 32'(result_o.new_node));
        compare_field("out_node_id", 32'(report_want.out_node_id),
                      32'(result_o.out_node_id));
        compare_field("out_sequence", 32'(report_want.out_sequence),
                      32'(result_o.out_sequence));
        compare_field("gap_count", 32'(report_want.gap_count), 32'(result_o.gap_count));
        compare_field("node_total_gaps", report_want.node_total_gaps,
                      result_o.node_total_gaps);
        compare_field("node_packets", report_want.node_packets, result_o.node_packets);
        compare_field("tracked_count", 32'(report_want.tracked_count),
                      32'(result_o.tracked_count));
        compare_field("anchor_seq", 32'(report_want.anchor_seq),
                      32'(result_o.anchor_seq));
        compare_field("anchor_pipe", 32'(report_want.anchor_pipe),
                      32'(result_o.anchor_pipe));
        compare_field("anchor_time", report_want.anchor_time, result_o.anchor_time);
      end
    end
  end

  task automatic send_frame(item_t f);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= f;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_reports.push_back(track_frame(f));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegSessionTag) cur_session_tag = value;
    else if (idx == RegCentralId) cur_central_id = value;
  endtask

  function automatic item_t make_frame(logic [5:0] len, logic [7:0] ftype,
                                       logic [7:0] node, logic [7:0] seq,
                                       logic [7:0] sess);
    item_t f;
    f.frame_len = len;
    f.frame_type = ftype;
    f.node_id = node;
    f.sequence_req = seq;
    f.frame_session = sess;
    f.node_time = $urandom();
    f.synced_time = $urandom();
    f.rx_time = $urandom();
    f.pipe = 3'($urandom_range(7));
    return f;
  endfunction

  function automatic logic [7:0] pool_node(int k);
    case (k)
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'h7F;
      4: return 8'h80;
      5: return 8'h55;
      6: return 8'hAA;
      7: return 8'h3C;
      8: return 8'hC3;
      default: return 8'h10;
    endcase
  endfunction

  // mostly well-formed frames from a small node pool, sequences mostly in order
  function automatic item_t random_frame();
    item_t      f;
    int         pick;
    logic [7:0] node;
    logic [7:0] seq;
    logic [5:0] len;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 85) node = pool_node($urandom_range(PoolSize - 1));
    else node = 8'($urandom());
    if ($urandom_range(4) == 0) seq = 8'($urandom());
    else seq = stim_next_seq[node];
    stim_next_seq[node] = seq + 8'd1;
    len = ($urandom_range(3) == 0) ? FrameMinBytes : 6'($urandom_range(63, 24));
    f = make_frame(len, TypeMocap, node, seq, cur_session_tag);
    if (pick < 5) begin
      f.frame_len = 6'($urandom());
      f.frame_type = 8'($urandom());
      f.frame_session = 8'($urandom());
    end else if (pick < 12) begin
      f.frame_len = 6'($urandom_range(23));
    end else if (pick < 19) begin
      f.frame_type = TypeMocap ^ 8'($urandom_range(255, 1));
    end else if (pick < 25) begin
      f.frame_session = cur_session_tag ^ 8'($urandom_range(255, 1));
    end
    return f;
  endfunction

  task automatic test_frame_filter_and_gaps();
    item_t f;
    int    p;
    idle_pct = 0;
    send_frame(make_frame(6'd0, TypeMocap, 8'h00, 8'h00, cur_session_tag));
    send_frame(make_frame(6'd23, TypeMocap, 8'h00, 8'h00, cur_session_tag));
    send_frame(make_frame(6'd24, TypeMocap ^ 8'h01, 8'h00, 8'h00, cur_session_tag));
    send_frame(make_frame(6'd32, TypeAnchor, 8'h00, 8'h00, cur_session_tag));
    send_frame(make_frame(6'd63, TypeMocap, 8'h00, 8'h00, cur_session_tag ^ 8'h80));
    // first word of node 0, all times zero on pipe 0
    f = make_frame(6'd24, TypeMocap, 8'h00, 8'h00, cur_session_tag);
    f.node_time = '0;
    f.synced_time = '0;
    f.rx_time = '0;
    f.pipe = '0;
    send_frame(f);
    send_frame(make_frame(6'd32, TypeMocap, 8'h00, 8'h01, cur_session_tag));
    send_frame(make_frame(6'd63, TypeMocap, 8'h00, 8'h05, cur_session_tag));
    // repeated sequence wraps the gap to 255
    send_frame(make_frame(6'd24, TypeMocap, 8'h00, 8'h05, cur_session_tag));
    send_frame(make_frame(6'd24, TypeMocap, 8'h00, 8'hFF, cur_session_tag));
    send_frame(make_frame(6'd24, TypeMocap, 8'h00, 8'h00, cur_session_tag));
    f = make_frame(6'd40, TypeMocap, 8'hFF, 8'hFF, cur_session_tag);
    f.node_time = '1;
    f.synced_time = '1;
    f.rx_time = '1;
    f.pipe = '1;
    send_frame(f);
    send_frame(make_frame(6'd24, TypeMocap, 8'hFF, 8'h00, cur_session_tag));
    send_frame(make_frame(6'd24, TypeMocap, 8'hFF, 8'hFE, cur_session_tag));
    for (p = 0; p < 8; p++) begin
      f = make_frame(6'd24 + 6'(p), TypeMocap, 8'h00, 8'(p + 1), cur_session_tag);
      f.pipe = 3'(p);
      send_frame(f);
    end
  endtask

  task automatic test_register_writes();
    wait_idle();
    write_reg(RegSessionTag, 8'hFF);
    write_reg(RegCentralId, 8'hFF);
    write_reg(RegSpareLo, 8'h00);
    write_reg(RegSpareHi, 8'h00);
    // the reset tag is now foreign
    send_frame(make_frame(6'd24, TypeMocap, 8'hFF, 8'hFF, 8'h00));
    send_frame(make_frame(6'd24, TypeMocap, 8'hFF, 8'hFF, 8'hFF));
  endtask

  task automatic test_random_traffic(int n, int pct, logic [7:0] tag, logic [7:0] cid);
    wait_idle();
    write_reg(RegSessionTag, tag);
    write_reg(RegCentralId, cid);
    idle_pct = pct;
    repeat (n) send_frame(random_frame());
  endtask

  task automatic test_table_saturation();
    int k;
    idle_pct = 0;
    for (k = 0; k < 12; k++) begin
      send_frame(make_frame(6'd40, TypeMocap, 8'h20 + 8'(k), 8'(k), cur_session_tag));
    end
  endtask

  initial begin
    int n;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    for (n = 0; n < MaxNodes; n++) begin
      tbl_valid[n] = 1'b0;
      tbl_node[n] = '0;
      tbl_packets[n] = '0;
      tbl_gaps[n] = '0;
      tbl_last_seq[n] = '0;
      tbl_node_time[n] = '0;
      tbl_synced_time[n] = '0;
      tbl_rx_time[n] = '0;
    end
    for (n = 0; n < 256; n++) stim_next_seq[n] = '0;
    tbl_fill = '0;
    anchor_next = '0;
    cur_session_tag = '0;
    cur_central_id = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_filter_and_gaps();
    test_register_writes();
    test_random_traffic(440, 0, 8'hFF, 8'hFF);
    test_random_traffic(440, 45, 8'($urandom()), 8'($urandom()));
    test_random_traffic(440, 21, 8'h00, 8'h00);
    test_table_saturation();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
